### src/acktr_pkg.sv
`default_nettype none

package acktr_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // operation codes
   localparam logic [1:0] FUNC_TRACK = 2'd0;
   localparam logic [1:0] FUNC_ACK   = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_TRACKED = 3'd0;
   localparam logic [2:0] KIND_BADLEN  = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_ACKED   = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;
   localparam logic [2:0] KIND_RETX    = 3'd5;
   localparam logic [2:0] KIND_GIVEUP  = 3'd6;
   localparam logic [2:0] KIND_IDLE    = 3'd7;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT     = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN     = 2'd2;

   localparam logic [15:0] TIMEOUT_RST     = 16'd100;
   localparam logic [7:0]  RETRY_LIMIT_RST = 8'd3;
   localparam logic [15:0] MAX_LEN_RST     = 16'd256;

   typedef struct packed {
      logic [15:0] seq;
      logic [31:0] deadline;
      logic [7:0]  retries;
      logic [15:0] len;
      logic [15:0] handle;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
      logic             vset;
      logic             vclr;
   } tbl_wr_type;

   typedef struct packed {
      logic        match;
      logic        expired;
      logic        at_limit;
      logic [31:0] deadline;
      logic [7:0]  retries_inc;
   } cmp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] seq;
      logic [15:0] handle;
      logic [15:0] len;
      logic [7:0]  retries;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

### src/acktr_table.sv
`default_nettype none

module acktr_table (
   input  logic                         clock,
   input  logic                         reset,
   input  acktr_pkg::tbl_wr_type        wr,
   input  logic [acktr_pkg::IDX_W-1:0]  rd_idx,
   output logic                         rd_valid,
   output acktr_pkg::entry_type         rd_data
);
   import acktr_pkg::*;

   logic [TABLE_DEPTH-1:0] valid_ff;
   entry_type              data_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.vset) begin
         valid_ff[wr.idx] <= 1'b1;
      end else if (wr.vclr) begin
         valid_ff[wr.idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         data_ff[wr.idx] <= wr.data;
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_data  = data_ff[rd_idx];

endmodule

`default_nettype wire

### src/acktr_cmp.sv
`default_nettype none

module acktr_cmp (
   input  acktr_pkg::entry_type ent,
   input  logic                 ent_valid,
   input  logic [15:0]          seq,
   input  logic [31:0]          now,
   input  logic [15:0]          timeout,
   input  logic [7:0]           limit,
   output acktr_pkg::cmp_type   res
);
   import acktr_pkg::*;

   logic [31:0] age;

   // wrap-aware: expired when deadline is now or up to 2^31-1 ms back
   assign age             = now - ent.deadline;
   assign res.match       = ent_valid && (ent.seq == seq);
   assign res.expired     = ent_valid && !age[31];
   assign res.at_limit    = (ent.retries >= limit);
   assign res.deadline    = now + {16'd0, timeout};
   assign res.retries_inc = ent.retries + 8'd1;

endmodule

`default_nettype wire

### src/acktr_ctrl.sv
`default_nettype none

module acktr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [15:0]                  req_seq_num,
   input  logic [31:0]                  req_now_time,
   input  logic [15:0]                  req_frame_handle,
   input  logic [15:0]                  req_frame_len,
   input  logic [15:0]                  max_len,
   input  logic                         out_free,
   output logic                         emit_valid,
   output acktr_pkg::rsp_type           emit_data,
   output logic [acktr_pkg::IDX_W-1:0]  rd_idx,
   input  logic                         rd_valid,
   input  acktr_pkg::entry_type         rd_data,
   input  acktr_pkg::cmp_type           cmp,
   output logic [15:0]                  item_seq,
   output logic [31:0]                  item_now,
   output acktr_pkg::tbl_wr_type        wr
);
   import acktr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       func_ff, func_in;
   logic [15:0]      seq_ff, seq_in;
   logic [31:0]      now_ff, now_in;
   logic [15:0]      handle_ff, handle_in;
   logic [15:0]      len_ff, len_in;
   logic             badlen_ff, badlen_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;

   logic req_badlen;
   logic last_slot;

   assign req_badlen = (req_frame_len == 16'd0) || (req_frame_len > max_len);
   assign last_slot  = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign req_ready  = (state_ff == S_IDLE);
   assign rd_idx     = (state_ff == S_FIN) ? hit_idx_ff : idx_ff;
   assign item_seq   = seq_ff;
   assign item_now   = now_ff;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      handle_in     = handle_ff;
      len_in        = len_ff;
      badlen_in     = badlen_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      emit_valid    = 1'b0;
      emit_data     = '0;
      wr            = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               seq_in        = req_seq_num;
               now_in        = req_now_time;
               handle_in     = req_frame_handle;
               len_in        = req_frame_len;
               badlen_in     = req_badlen;
               idx_in        = '0;
               n_in          = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               pend_valid_in = 1'b0;
               if ((req_func == FUNC_TRACK && !req_badlen) || req_func == FUNC_ACK ||
                   req_func == FUNC_TICK) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         S_SCAN: begin
            if (func_ff == FUNC_TICK) begin
               if (cmp.expired) begin
                  // a held result must leave before the next one takes its place
                  if (!pend_valid_ff || out_free) begin
                     emit_valid = pend_valid_ff;
                     emit_data  = pend_ff;
                     wr.idx     = idx_ff;
                     pend_in    = '0;
                     if (cmp.at_limit) begin
                        wr.vclr         = 1'b1;
                        pend_in.kind    = KIND_GIVEUP;
                        pend_in.retries = rd_data.retries;
                     end else begin
                        wr.en               = 1'b1;
                        wr.data             = rd_data;
                        wr.data.retries     = cmp.retries_inc;
                        wr.data.deadline    = cmp.deadline;
                        pend_in.kind        = KIND_RETX;
                        pend_in.retries     = cmp.retries_inc;
                     end
                     pend_in.seq    = rd_data.seq;
                     pend_in.handle = rd_data.handle;
                     pend_in.len    = rd_data.len;
                     pend_valid_in  = 1'b1;
                     n_in           = n_ff + CNT_W'(1);
                     if (last_slot || n_ff == CNT_W'(MAX_RESULTS - 1)) begin
                        state_in = S_FIN;
                     end else begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
               end else if (last_slot) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               if (cmp.match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
                  state_in   = S_FIN;
               end else begin
                  if (!rd_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = idx_ff;
                  end
                  if (last_slot) begin
                     state_in = S_FIN;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               emit_valid     = 1'b1;
               emit_data.last = 1'b1;
               state_in       = S_IDLE;
               case (func_ff)
                  FUNC_TRACK: begin
                     emit_data.seq    = seq_ff;
                     emit_data.handle = handle_ff;
                     emit_data.len    = len_ff;
                     if (badlen_ff) begin
                        emit_data.kind = KIND_BADLEN;
                     end else if (hit_ff || free_ff) begin
                        wr.en            = 1'b1;
                        wr.vset          = 1'b1;
                        wr.idx           = hit_ff ? hit_idx_ff : free_idx_ff;
                        wr.data.seq      = seq_ff;
                        wr.data.deadline = cmp.deadline;
                        wr.data.retries  = 8'd0;
                        wr.data.len      = len_ff;
                        wr.data.handle   = handle_ff;
                        emit_data.kind   = KIND_TRACKED;
                     end else begin
                        emit_data.kind = KIND_FULL;
                     end
                  end
                  FUNC_ACK: begin
                     emit_data.seq = seq_ff;
                     if (hit_ff) begin
                        wr.vclr           = 1'b1;
                        wr.idx            = hit_idx_ff;
                        emit_data.kind    = KIND_ACKED;
                        emit_data.handle  = rd_data.handle;
                        emit_data.len     = rd_data.len;
                        emit_data.retries = rd_data.retries;
                     end else begin
                        emit_data.kind = KIND_UNKNOWN;
                     end
                  end
                  FUNC_TICK: begin
                     if (pend_valid_ff) begin
                        emit_data      = pend_ff;
                        emit_data.last = 1'b1;
                     end else begin
                        emit_data.kind = KIND_IDLE;
                     end
                     pend_valid_in = 1'b0;
                  end
                  default: begin
                     emit_data.kind = KIND_IDLE;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         n_ff          <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      seq_ff      <= seq_in;
      now_ff      <= now_in;
      handle_ff   <= handle_in;
      len_ff      <= len_in;
      badlen_ff   <= badlen_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
   end

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_RESULTS))
      else $error("tick result count over cap");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_free)
      else $error("result emitted into a full output register");

   a_last_in_fin: assert property (@(posedge clock) disable iff (reset)
      (emit_valid && emit_data.last) |-> state_ff == S_FIN)
      else $error("final result emitted outside the finish step");

   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> state_ff == S_IDLE)
      else $error("finish step did not return to idle");

   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && state_ff != S_IDLE) |-> func_ff == FUNC_TICK)
      else $error("held result outside a tick");

endmodule

`default_nettype wire

### src/ack_retransmit_tracker_unit.sv
`default_nettype none
// Flow: a track or ack item scans the table one slot a cycle (a sequence match stops early),
// then a finish step loads the result register once it is free; a bad-length track or unused
// code skips the scan. A tick always scans all TABLE_DEPTH slots through the shared compare unit;
// each expired slot adds a result, and the scan waits while a held result cannot leave. A new
// item is taken only in idle, once the last one is done. Reset (synchronous) clears all slot
// valid bits and loads the register defaults; no clearing pass is needed.

module ack_retransmit_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_seq_num,
   input  logic [31:0] req_now_time,
   input  logic [15:0] req_frame_handle,
   input  logic [15:0] req_frame_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_out_seq,
   output logic [15:0] rsp_out_handle,
   output logic [15:0] rsp_out_len,
   output logic [7:0]  rsp_retry_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import acktr_pkg::*;

   logic [15:0] timeout_ff;
   logic [7:0]  limit_ff;
   logic [15:0] max_len_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic             out_free;
   logic             emit_valid;
   rsp_type          emit_data;
   logic [IDX_W-1:0] rd_idx;
   logic             rd_valid;
   entry_type        rd_data;
   cmp_type          cmp;
   logic [15:0]      item_seq;
   logic [31:0]      item_now;
   tbl_wr_type       wr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         limit_ff   <= RETRY_LIMIT_RST;
         max_len_ff <= MAX_LEN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT:     timeout_ff <= csr_data;
            CSR_RETRY_LIMIT: limit_ff   <= csr_data[7:0];
            CSR_MAX_LEN:     max_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // output register parts the result side from the scan
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_data_ff.kind;
   assign rsp_out_seq     = rsp_data_ff.seq;
   assign rsp_out_handle  = rsp_data_ff.handle;
   assign rsp_out_len     = rsp_data_ff.len;
   assign rsp_retry_count = rsp_data_ff.retries;
   assign rsp_last        = rsp_data_ff.last;

   acktr_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_idx   (rd_idx),
      .rd_valid (rd_valid),
      .rd_data  (rd_data)
   );

   acktr_cmp u_cmp (
      .ent       (rd_data),
      .ent_valid (rd_valid),
      .seq       (item_seq),
      .now       (item_now),
      .timeout   (timeout_ff),
      .limit     (limit_ff),
      .res       (cmp)
   );

   acktr_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_seq_num      (req_seq_num),
      .req_now_time     (req_now_time),
      .req_frame_handle (req_frame_handle),
      .req_frame_len    (req_frame_len),
      .max_len          (max_len_ff),
      .out_free         (out_free),
      .emit_valid       (emit_valid),
      .emit_data        (emit_data),
      .rd_idx           (rd_idx),
      .rd_valid         (rd_valid),
      .rd_data          (rd_data),
      .cmp              (cmp),
      .item_seq         (item_seq),
      .item_now         (item_now),
      .wr               (wr)
   );

endmodule

`default_nettype wire
